[rtl/core/gna_pkg.sv]
// ---------------------------------------------------------------------------
// gna_pkg
// Shared widths, constants and the arctangent table of the gradient
// norm and angle stream.
// ---------------------------------------------------------------------------
package gna_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int HEIGHT_LIMIT   = 4096;
   localparam int PIXEL_BITS     = 8;
   localparam int NORM_FRAC_BITS = 6;

   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int POS_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int NORM_W  = 15;
   localparam int ANGLE_W = 16;

   localparam int DIFF_W  = PIXEL_BITS + 1;
   localparam int GRAD_W  = PIXEL_BITS + 2;
   localparam int SQ_W    = 2 * PIXEL_BITS + 1;
   localparam int RAD_W   = SQ_W + 2 * NORM_FRAC_BITS + 1;
   localparam int ROOT_W  = (RAD_W + 1) / 2;

   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int CORDIC_PRE   = 12;
   localparam int CORDIC_W     = GRAD_W + CORDIC_PRE + 4;
   localparam int ACC_W        = 32;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
   localparam logic [NORM_W-1:0] THRESH_RESET = NORM_W'(334);
   localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(HEIGHT_LIMIT);

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH = 2'd2;
   localparam int CSR_DATA_W = 15;

   // atan(2^-i) scaled so that 2^32 is a full turn
   function automatic logic [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [ACC_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/gna_ram.sv]
// ---------------------------------------------------------------------------
// gna_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/gna_sqrt.sv]
// ---------------------------------------------------------------------------
// gna_sqrt
// Iterative integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module gna_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gna_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [gna_pkg::ROOT_W-1:0] root
);

   localparam int W = gna_pkg::RAD_W;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] bit_ff, bit_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = W'(1) << (2 * (gna_pkg::ROOT_W - 1));
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[gna_pkg::ROOT_W-1:0];

endmodule

[rtl/core/gna_cordic.sv]
// ---------------------------------------------------------------------------
// gna_cordic
// Iterative CORDIC in vectoring mode: binary angle of atan2(gx, -gy).
// ---------------------------------------------------------------------------
module gna_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [gna_pkg::GRAD_W-1:0]  gx,
   input  logic signed [gna_pkg::GRAD_W-1:0]  gy,
   output logic                               done,
   output logic [gna_pkg::ANGLE_W-1:0]        angle
);

   localparam int CW = gna_pkg::CORDIC_W;
   localparam int AW = gna_pkg::ACC_W;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic        [AW-1:0] acc_ff, acc_in;
   logic [gna_pkg::STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [CW-1:0] x0, y0, xs, ys;
   logic [AW-1:0] rounded;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      x0 = -(CW'(gy) <<< gna_pkg::CORDIC_PRE);
      y0 = CW'(gx) <<< gna_pkg::CORDIC_PRE;
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         // fold the left half plane onto the right one
         if (x0 < 0) begin
            x_in   = -x0;
            y_in   = -y0;
            acc_in = AW'(1) << (AW - 1);
         end else begin
            x_in   = x0;
            y_in   = y0;
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            acc_in = acc_ff + gna_pkg::atan_entry(step_ff);
         end else begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            acc_in = acc_ff - gna_pkg::atan_entry(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == gna_pkg::STEP_W'(gna_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign rounded = acc_ff + AW'(32'h8000);
   assign done    = done_ff;
   assign angle   = rounded[AW-1:AW-gna_pkg::ANGLE_W];

endmodule

[rtl/core/gradient_norm_angle_stream.sv]
// ---------------------------------------------------------------------------
// gradient_norm_angle_stream
// 2x2 gradient, norm and angle of a raster pixel stream.
// ---------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order; req_frame_start marks
// pixel (0,0). Each pixel at column >= 1 and row >= 1 yields one item on the
// rsp_ channel for the pixel up and to the left; other pixels yield nothing.
// The previous row sits in a 4096 x 8 line RAM whose data is read in the
// cycle after accept. An item with no result ends after the RAM read; one
// whose norm is at or below the threshold adds a 15-step square root.
// With a defined angle, a 20-step CORDIC follows before the result reaches
// rsp_valid. One item is in flight at a time, set by the shared square root
// and CORDIC units; a new pixel is accepted while the last result still
// waits in the output register, but a result is held until the receiver
// takes the previous one. csr_ writes land at once; write only while idle.
// Reset clears position, running maximum and the output valid flag and loads
// the register defaults 640 x 480, threshold 334; the line RAM is not
// cleared and needs one full row before it is read.
// ---------------------------------------------------------------------------
module gradient_norm_angle_stream (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [gna_pkg::PIXEL_BITS-1:0]         req_pixel,
   input  logic                                   req_frame_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gna_pkg::POS_W-1:0]              rsp_col,
   output logic [gna_pkg::POS_W-1:0]              rsp_row,
   output logic [gna_pkg::NORM_W-1:0]             rsp_grad_norm,
   output logic [gna_pkg::ANGLE_W-1:0]            rsp_angle,
   output logic                                   rsp_angle_defined,
   output logic [gna_pkg::NORM_W-1:0]             rsp_max_norm,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [gna_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gna_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int PW = gna_pkg::POS_W;
   localparam int SW = gna_pkg::SIZE_W;
   localparam int NW = gna_pkg::NORM_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SQRT  = 3'd2;
   localparam logic [2:0] ST_ANGLE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [SW-1:0] width_ff, height_ff;
   logic [NW-1:0] thresh_ff;
   logic [SW-1:0] w_eff, h_eff;

   logic [PW-1:0] col_ff, col_in, row_ff, row_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic [gna_pkg::PIXEL_BITS-1:0] d_ff, d_in, left_ff, left_in, upleft_ff, upleft_in;
   logic [NW-1:0] max_ff, max_in;
   logic last_ff, last_in;
   logic signed [gna_pkg::GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [NW-1:0] norm_ff, norm_in;
   logic def_ff, def_in;

   logic out_valid_ff, out_valid_in;
   logic [PW-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [NW-1:0] out_norm_ff, out_norm_in, out_max_ff, out_max_in;
   logic [gna_pkg::ANGLE_W-1:0] out_angle_ff, out_angle_in;
   logic out_def_ff, out_def_in, out_last_ff, out_last_in;

   logic accept;
   logic [SW-1:0] cx, cy, nx, ny;
   logic [gna_pkg::PIXEL_BITS-1:0] b_data;
   logic signed [gna_pkg::DIFF_W-1:0] da, bc;
   logic [gna_pkg::SQ_W-1:0] sq;
   logic [gna_pkg::RAD_W-1:0] radicand;
   logic sqrt_start, sqrt_done, cordic_start, cordic_done;
   logic [gna_pkg::ROOT_W-1:0] root;
   logic [gna_pkg::ROOT_W:0] half_up;
   logic [NW-1:0] norm_sat;
   logic [gna_pkg::ANGLE_W-1:0] cordic_angle;
   logic mem_wr_en;

   function automatic logic signed [gna_pkg::GRAD_W-1:0] GRAD_EXT(
      input logic signed [gna_pkg::DIFF_W-1:0] v);
      return gna_pkg::GRAD_W'(v);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gna_pkg::WIDTH_RESET;
         height_ff <= gna_pkg::HEIGHT_RESET;
         thresh_ff <= gna_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gna_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[SW-1:0];
            gna_pkg::CSR_HEIGHT: height_ff <= csr_wdata[SW-1:0];
            gna_pkg::CSR_THRESH: thresh_ff <= csr_wdata[NW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff < gna_pkg::SIZE_MIN) w_eff = gna_pkg::SIZE_MIN;
      else if (width_ff > gna_pkg::WIDTH_MAX) w_eff = gna_pkg::WIDTH_MAX;
      h_eff = height_ff;
      if (height_ff < gna_pkg::SIZE_MIN) h_eff = gna_pkg::SIZE_MIN;
      else if (height_ff > gna_pkg::HEIGHT_MAX) h_eff = gna_pkg::HEIGHT_MAX;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // position of the incoming pixel and of the one after it
   always_comb begin
      cx = req_frame_start ? '0 : SW'(col_ff);
      cy = req_frame_start ? '0 : SW'(row_ff);
      if (cx >= w_eff) begin
         cx = '0;
         cy = cy + 1'b1;
      end
      if (cy >= h_eff) cy = '0;
      if (cx + 1'b1 >= w_eff) begin
         nx = '0;
         ny = cy + 1'b1;
         if (ny >= h_eff) ny = '0;
      end else begin
         nx = cx + 1'b1;
         ny = cy;
      end
   end

   gna_ram #(
      .WIDTH(gna_pkg::PIXEL_BITS),
      .DEPTH(gna_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(x_ff[gna_pkg::ADDR_W-1:0]),
      .wr_data(d_ff),
      .rd_en  (accept),
      .rd_addr(cx[gna_pkg::ADDR_W-1:0]),
      .rd_data(b_data)
   );

   assign mem_wr_en = (state_ff == ST_READ);

   assign da = $signed({1'b0, d_ff}) - $signed({1'b0, upleft_ff});
   assign bc = $signed({1'b0, b_data}) - $signed({1'b0, left_ff});
   assign sq = gna_pkg::SQ_W'(da * da) + gna_pkg::SQ_W'(bc * bc);
   assign radicand = gna_pkg::RAD_W'(sq) << (2 * gna_pkg::NORM_FRAC_BITS + 1);
   assign sqrt_start = (state_ff == ST_READ) && (x_ff != '0) && (y_ff != '0);

   gna_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand(radicand),
      .done    (sqrt_done),
      .root    (root)
   );

   assign half_up  = ({1'b0, root} + 1'b1) >> 1;
   assign norm_sat = (half_up > (gna_pkg::ROOT_W+1)'((1 << NW) - 1)) ?
                     '1 : NW'(half_up);
   assign cordic_start = sqrt_done && (norm_sat > thresh_ff);

   gna_cordic u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cordic_start),
      .gx   (gx_ff),
      .gy   (gy_ff),
      .done (cordic_done),
      .angle(cordic_angle)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      d_in         = d_ff;
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      norm_in      = norm_ff;
      def_in       = def_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_norm_in  = out_norm_ff;
      out_angle_in = out_angle_ff;
      out_def_in   = out_def_ff;
      out_max_in   = out_max_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = PW'(cx);
               y_in    = PW'(cy);
               d_in    = req_pixel;
               col_in  = PW'(nx);
               row_in  = PW'(ny);
               last_in = (cx == w_eff - 1'b1) && (cy == h_eff - 1'b1);
               if (cx == '0 && cy == '0) max_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            gx_in     = GRAD_EXT(da) + GRAD_EXT(bc);
            gy_in     = GRAD_EXT(da) - GRAD_EXT(bc);
            upleft_in = b_data;
            left_in   = d_ff;
            state_in  = sqrt_start ? ST_SQRT : ST_IDLE;
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               norm_in  = norm_sat;
               def_in   = cordic_start;
               state_in = cordic_start ? ST_ANGLE : ST_DONE;
            end
         end
         ST_ANGLE: begin
            // the CORDIC holds its angle until the next start
            if (cordic_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_col_in   = x_ff - 1'b1;
               out_row_in   = y_ff - 1'b1;
               out_norm_in  = norm_ff;
               out_def_in   = def_ff;
               out_last_in  = last_ff;
               out_angle_in = def_ff ? cordic_angle : '0;
               if (def_ff && norm_ff > max_ff) begin
                  max_in     = norm_ff;
                  out_max_in = norm_ff;
               end else begin
                  out_max_in = max_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      d_ff         <= d_in;
      last_ff      <= last_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      norm_ff      <= norm_in;
      def_ff       <= def_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_norm_ff  <= out_norm_in;
      out_angle_ff <= out_angle_in;
      out_def_ff   <= out_def_in;
      out_max_ff   <= out_max_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_col           = out_col_ff;
   assign rsp_row           = out_row_ff;
   assign rsp_grad_norm     = out_norm_ff;
   assign rsp_angle         = out_angle_ff;
   assign rsp_angle_defined = out_def_ff;
   assign rsp_max_norm      = out_max_ff;
   assign rsp_last          = out_last_ff;

   a_sqrt_done_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQRT)
      else $error("square root finished outside its state");

   a_cordic_done_in_angle: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_ANGLE)
      else $error("cordic finished outside its state");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded without a finished item");

   a_max_covers_norm: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_def_ff) |-> out_max_ff >= out_norm_ff)
      else $error("running maximum below a defined norm");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for gradient_norm_angle_stream
// Streams raster frames of varied size, threshold and content through the
// block. A predictor keeps its own line store and position, and works out
// the gradient, norm, angle and running maximum for each accepted pixel that
// yields a result. Each result item is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [gna_pkg::PIXEL_BITS-1:0] pixel;
      logic                           frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [gna_pkg::POS_W-1:0]   col;
      logic [gna_pkg::POS_W-1:0]   row;
      logic [gna_pkg::NORM_W-1:0]  grad_norm;
      logic [gna_pkg::ANGLE_W-1:0] angle;
      logic                        angle_defined;
      logic [gna_pkg::NORM_W-1:0]  max_norm;
      logic                        last;
   } gradient_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [gna_pkg::PIXEL_BITS-1:0]     req_pixel = '0;
   logic                               req_frame_start = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [gna_pkg::POS_W-1:0]          rsp_col;
   logic [gna_pkg::POS_W-1:0]          rsp_row;
   logic [gna_pkg::NORM_W-1:0]         rsp_grad_norm;
   logic [gna_pkg::ANGLE_W-1:0]        rsp_angle;
   logic                               rsp_angle_defined;
   logic [gna_pkg::NORM_W-1:0]         rsp_max_norm;
   logic                               rsp_last;
   logic                               csr_wr_en = 1'b0;
   logic [gna_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [gna_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   gradient_norm_angle_stream dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [gna_pkg::PIXEL_BITS-1:0] row_mem [gna_pkg::MAX_WIDTH];
   logic [gna_pkg::PIXEL_BITS-1:0] left_px = '0, upleft_px = '0;
   int unsigned                    pos_col = 0, pos_row = 0, run_max = 0;
   logic [gna_pkg::SIZE_W-1:0]     cfg_width = gna_pkg::WIDTH_RESET;
   logic [gna_pkg::SIZE_W-1:0]     cfg_height = gna_pkg::HEIGHT_RESET;
   logic [gna_pkg::NORM_W-1:0]     cfg_thresh = gna_pkg::THRESH_RESET;

   pixel_item_type pending_pixels[$];
   gradient_type   expected_grads[$];
   int          fail_cnt = 0, grad_cnt = 0, frame_cnt = 0, defined_cnt = 0;
   int          snd_idle = 17, rcv_idle = 79;
   bit          req_taken = 0, hold_start = 0, hold_done = 0;
   int          hold_cnt = 0;

   localparam int unsigned ATAN_TAB [gna_pkg::CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304};

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [gna_pkg::ANGLE_W-1:0] vector_angle(longint gx, longint gy);
      longint      vx, vy, xs, ys;
      logic [31:0] acc;
      vx = -gy * 4096;
      vy = gx * 4096;
      acc = '0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < gna_pkg::CORDIC_STEPS; i++) begin
         xs = vx >>> i;
         ys = vy >>> i;
         if (vy > 0) begin
            vx += ys; vy -= xs; acc += ATAN_TAB[i];
         end else begin
            vx -= ys; vy += xs; acc -= ATAN_TAB[i];
         end
      end
      acc = acc + 32'h8000;
      return acc[31:16];
   endfunction

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      return v < 2 ? 2 : (v > hi ? hi : v);
   endfunction

   // advance position, update line store, queue the gradient if one is due
   task automatic predict_gradient(pixel_item_type it);
      int unsigned     w, h, x, y, norm;
      logic [gna_pkg::PIXEL_BITS-1:0] above;
      longint          da, bc;
      longint unsigned nv;
      gradient_type    g;
      w = clamp_size(cfg_width, gna_pkg::MAX_WIDTH);
      h = clamp_size(cfg_height, gna_pkg::HEIGHT_LIMIT);
      if (it.frame_start) begin
         pos_col = 0;
         pos_row = 0;
      end
      x = pos_col;
      y = pos_row;
      if (x >= w) begin
         x = 0;
         y++;
      end
      if (y >= h) y = 0;
      if (x == 0 && y == 0) begin
         run_max = 0;
         frame_cnt++;
      end
      above = row_mem[x];
      if (x >= 1 && y >= 1) begin
         da = longint'(it.pixel) - longint'(upleft_px);
         bc = longint'(above) - longint'(left_px);
         nv = (int_sqrt(longint'(da * da + bc * bc) << (2 * gna_pkg::NORM_FRAC_BITS + 1))
               + 1) / 2;
         norm = nv > 32767 ? 32767 : int'(nv);
         g.col = gna_pkg::POS_W'(x - 1);
         g.row = gna_pkg::POS_W'(y - 1);
         g.grad_norm = gna_pkg::NORM_W'(norm);
         g.angle_defined = norm > cfg_thresh;
         g.angle = '0;
         if (g.angle_defined) begin
            g.angle = vector_angle(da + bc, da - bc);
            if (norm > run_max) run_max = norm;
         end
         g.max_norm = gna_pkg::NORM_W'(run_max);
         g.last = (x == w - 1) && (y == h - 1);
         expected_grads = {expected_grads, g};
      end
      upleft_px = above;
      left_px = it.pixel;
      row_mem[x] = it.pixel;
      if (x + 1 >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end else begin
         x++;
      end
      pos_col = x;
      pos_row = y;
   endtask

   // accept side: predict on each item taken
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_gradient('{pixel: req_pixel, frame_start: req_frame_start});
         req_taken = 1;
      end
   end

   // driver: offer the next pending item once the current one is taken
   always @(negedge clock) begin
      if (!reset && (req_taken || !req_valid)) begin
         pixel_item_type nxt;
         req_taken = 0;
         if (pending_pixels.size() > 0 && $urandom_range(99) >= snd_idle) begin
            nxt = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_pixel <= nxt.pixel;
            req_frame_start <= nxt.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver ready, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_start && !hold_done) begin
         hold_done <= 1;
         hold_cnt <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         gradient_type e;
         if (expected_grads.size() == 0) begin
            $error("result item with none expected: col %0d row %0d", rsp_col, rsp_row);
            fail_cnt++;
         end else begin
            e = expected_grads.pop_front();
            grad_cnt++;
            if (e.angle_defined) defined_cnt++;
            if (rsp_col !== e.col) begin
               $error("col: expected %0d actual %0d", e.col, rsp_col);
               fail_cnt++;
            end
            if (rsp_row !== e.row) begin
               $error("row: expected %0d actual %0d", e.row, rsp_row);
               fail_cnt++;
            end
            if (rsp_grad_norm !== e.grad_norm) begin
               $error("grad_norm: expected %0d actual %0d", e.grad_norm, rsp_grad_norm);
               fail_cnt++;
            end
            if (rsp_angle !== e.angle) begin
               $error("angle: expected %0d actual %0d", e.angle, rsp_angle);
               fail_cnt++;
            end
            if (rsp_angle_defined !== e.angle_defined) begin
               $error("angle_defined: expected %0d actual %0d",
                      e.angle_defined, rsp_angle_defined);
               fail_cnt++;
            end
            if (rsp_max_norm !== e.max_norm) begin
               $error("max_norm: expected %0d actual %0d", e.max_norm, rsp_max_norm);
               fail_cnt++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_last);
               fail_cnt++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_grads.size() != 0)
         @(posedge clock);
      // let a trailing no-result item finish
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [gna_pkg::CSR_INDEX_W-1:0] idx,
                            logic [gna_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == gna_pkg::CSR_WIDTH) cfg_width = val[gna_pkg::SIZE_W-1:0];
      else if (idx == gna_pkg::CSR_HEIGHT) cfg_height = val[gna_pkg::SIZE_W-1:0];
      else if (idx == gna_pkg::CSR_THRESH) cfg_thresh = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic configure(int w, int h, int thr);
      wait_idle();
      write_csr(gna_pkg::CSR_WIDTH, gna_pkg::CSR_DATA_W'(w));
      write_csr(gna_pkg::CSR_HEIGHT, gna_pkg::CSR_DATA_W'(h));
      write_csr(gna_pkg::CSR_THRESH, gna_pkg::CSR_DATA_W'(thr));
   endtask

   function automatic logic [gna_pkg::PIXEL_BITS-1:0] rand_pixel();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return gna_pkg::PIXEL_BITS'($urandom);
      endcase
   endfunction

   // whole frames with random content, a few restarted early
   task automatic queue_frames(int count, int noise_pct);
      int w, h, pos;
      w = clamp_size(cfg_width, gna_pkg::MAX_WIDTH);
      h = clamp_size(cfg_height, gna_pkg::HEIGHT_LIMIT);
      pos = 0;
      for (int i = 0; i < count; i++) begin
         pixel_item_type it;
         it.pixel = rand_pixel();
         it.frame_start = (pos == 0) || ($urandom_range(99) < noise_pct);
         if (it.frame_start) pos = 0;
         pending_pixels = {pending_pixels, it};
         pos = (pos + 1 == w * h) ? 0 : pos + 1;
      end
   endtask

   task automatic queue_pixel(int px, bit fs);
      pixel_item_type it;
      it.pixel = gna_pkg::PIXEL_BITS'(px);
      it.frame_start = fs;
      pending_pixels = {pending_pixels, it};
   endtask

   initial begin
      int w_pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero and full gradients, both diagonals, size clamps
      configure(3, 3, 0);
      queue_pixel(0, 1); queue_pixel(255, 0); queue_pixel(0, 0);
      queue_pixel(255, 0); queue_pixel(0, 0); queue_pixel(255, 0);
      queue_pixel(0, 0); queue_pixel(255, 0); queue_pixel(0, 0);
      queue_pixel(7, 1); queue_pixel(7, 0); queue_pixel(7, 0);
      queue_pixel(7, 0); queue_pixel(7, 0); queue_pixel(255, 0);
      queue_pixel(255, 0); queue_pixel(0, 0); queue_pixel(255, 0);
      configure(1, 0, 32767);
      queue_pixel(255, 1); queue_pixel(0, 0); queue_pixel(0, 0); queue_pixel(255, 0);
      queue_pixel(0, 0); queue_pixel(255, 0); queue_pixel(255, 0); queue_pixel(0, 0);

      for (int p = 0; p < 6; p++) begin
         w_pick = $urandom_range(2, 10);
         configure(($urandom_range(9) == 0) ? 1 : w_pick, $urandom_range(2, 6),
                   (p == 0) ? 0 : (p == 5) ? 32767 : $urandom_range(0, 1200));
         snd_idle = (p < 2) ? 17 : (p < 4) ? 79 : 0;
         rcv_idle = (p < 2) ? 79 : (p < 4) ? 17 : 0;
         if (p == 2) hold_start = 1;
         queue_frames(84, 3);
      end

      // height above the limit clamps to the tallest frame
      configure(2, 8191, 800);
      queue_frames(24, 0);

      wait_idle();
      $display("covered %0d frames, %0d gradient items checked, %0d with angle",
               frame_cnt, grad_cnt, defined_cnt);
      if (fail_cnt == 0) begin
         $display("gradient_norm_angle_stream regression: pass");
      end else begin
         $display("gradient_norm_angle_stream regression: fail");
      end
      $finish;
   end

   initial begin
      #36_000_000;
      $display("timeout waiting for result items");
      $display("gradient_norm_angle_stream regression: fail");
      $finish;
   end

endmodule
